// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/sis_pkg.sv =====
// Shared types, constants and the hash step for the sorted id set.
// No dependencies.
package sis_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_WIDTH_DEF = 32;
  localparam int HASH_W       = 64;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } hash_ctl_t;

  // XOR in one word, then multiply by the prime 2^40 + 0x1B3 modulo 2^64.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [HASH_W-1:0] x);
    logic [HASH_W-1:0] t;
    t = h ^ x;
    return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
  endfunction

endpackage

// ===== hw/rtl/sorted_id_set_with_fnv_hash_unit.sv =====
// Sorted id set with cached FNV-1a style hash. Depends on sis_pkg, sis_mem, sis_hash.
// A query or no-op command scans the entry memory serially (skipped when the set is empty),
// then answers; an add or remove that changes the set adds one pass that shifts entries
// and steps the hash unit once per entry; a clear answers straight from idle.
// One command at a time: the next is taken the cycle after the result is taken.
// Synchronous active-low reset empties the set and zeroes the hash.
module sorted_id_set_with_fnv_hash_unit
  import sis_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_entry_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic        out_overflow,
  output logic [5:0]  out_entry_count,
  output logic [63:0] out_set_hash
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_PRIME  = 3'd3;
  localparam logic [2:0] ST_BUILD  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [ID_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    new_cnt_r, new_cnt_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic                present_r, present_nxt;
  logic                found_r, found_nxt;
  logic                ovf_r, ovf_nxt;
  logic [ID_WIDTH-1:0] carry_r, carry_nxt;

  logic [63:0]         id_ext;
  logic [ID_WIDTH-1:0] in_key;
  logic [CNT_W-1:0]    k_inc;
  logic [CNT_W:0]      src_idx;
  logic [CNT_W:0]      src0_idx;
  logic [ID_WIDTH-1:0] new_val;
  logic [63:0]         cnt_ext;

  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [ID_WIDTH-1:0] rd_data, wr_data;

  hash_ctl_t           hctl;
  logic [ID_WIDTH-1:0] hdata;
  logic [HASH_W-1:0]   digest;

  assign id_ext = 64'(in_entry_id);
  assign in_key = id_ext[ID_WIDTH-1:0];
  assign k_inc  = k_r + CNT_W'(1);

  // Source index of the next element: a remove skips the deleted slot.
  assign src_idx  = (cmd_r == CMD_REMOVE && k_inc >= pos_r) ?
                    ({1'b0, k_inc} + (CNT_W+1)'(1)) : {1'b0, k_inc};
  assign src0_idx = (cmd_r == CMD_REMOVE && pos_r == '0) ?
                    (CNT_W+1)'(1) : '0;

  // Element of the rebuilt set: an add inserts the key at pos and shifts up.
  always_comb begin
    new_val = rd_data;
    if (cmd_r == CMD_ADD) begin
      if (k_r == pos_r) begin
        new_val = key_r;
      end else if (k_r > pos_r) begin
        new_val = carry_r;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    new_cnt_nxt = new_cnt_r;
    k_nxt       = k_r;
    pos_nxt     = pos_r;
    present_nxt = present_r;
    found_nxt   = found_r;
    ovf_nxt     = ovf_r;
    carry_nxt   = carry_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = k_r[IDX_W-1:0];
    wr_data     = new_val;
    hctl        = '0;
    hdata       = new_val;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          key_nxt   = in_key;
          found_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          if (in_command == CMD_CLEAR) begin
            cnt_nxt    = '0;
            hctl.clear = 1'b1;
            state_nxt  = ST_DONE;
          end else if (cnt_r == '0) begin
            pos_nxt     = '0;
            present_nxt = 1'b0;
            state_nxt   = ST_DECIDE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            k_nxt     = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        // Stop at the first entry not below the key, or past the last one.
        if (rd_data >= key_r || k_inc == cnt_r) begin
          pos_nxt     = (rd_data >= key_r) ? k_r : cnt_r;
          present_nxt = (rd_data == key_r);
          state_nxt   = ST_DECIDE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = k_inc[IDX_W-1:0];
          k_nxt   = k_inc;
        end
      end

      ST_DECIDE: begin
        found_nxt = present_r;
        state_nxt = ST_DONE;
        case (cmd_r)
          CMD_ADD: begin
            if (!present_r) begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                ovf_nxt = 1'b1;
              end else begin
                new_cnt_nxt = cnt_r + CNT_W'(1);
                state_nxt   = ST_PRIME;
              end
            end
          end
          CMD_REMOVE: begin
            if (present_r) begin
              new_cnt_nxt = cnt_r - CNT_W'(1);
              state_nxt   = ST_PRIME;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_PRIME: begin
        hctl.load = 1'b1;
        k_nxt     = '0;
        if (new_cnt_r == '0) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          rd_en     = (src0_idx < {1'b0, cnt_r});
          rd_addr   = src0_idx[IDX_W-1:0];
          state_nxt = ST_BUILD;
        end
      end

      ST_BUILD: begin
        wr_en     = 1'b1;
        hctl.step = 1'b1;
        if (cmd_r == CMD_ADD && k_r >= pos_r) begin
          carry_nxt = rd_data;
        end
        if (k_inc == new_cnt_r) begin
          cnt_nxt   = new_cnt_r;
          state_nxt = ST_DONE;
        end else begin
          rd_en   = (src_idx < {1'b0, cnt_r});
          rd_addr = src_idx[IDX_W-1:0];
          k_nxt   = k_inc;
        end
      end

      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    new_cnt_r <= new_cnt_nxt;
    k_r       <= k_nxt;
    pos_r     <= pos_nxt;
    present_r <= present_nxt;
    found_r   <= found_nxt;
    ovf_r     <= ovf_nxt;
    carry_r   <= carry_nxt;
  end

  sis_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ID_WIDTH),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sis_hash #(
    .ID_WIDTH (ID_WIDTH)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hctl),
    .data   (hdata),
    .digest (digest)
  );

  always_comb begin
    cnt_ext = '0;
    cnt_ext[CNT_W-1:0] = cnt_r;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_DONE);
  assign out_found       = found_r;
  assign out_overflow    = ovf_r;
  assign out_entry_count = cnt_ext[5:0];
  assign out_set_hash    = digest;

endmodule

// ===== hw/rtl/sis_mem.sv =====
// Entry memory for the sorted id set: one write and one registered read per cycle.
// No package dependencies.
module sis_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/sis_hash.sv =====
// Cached digest register and the FNV step unit.
// Depends on sis_pkg for the hash constants, step function and control struct.
module sis_hash
  import sis_pkg::*;
#(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hash_ctl_t           ctl,
  input  logic [ID_WIDTH-1:0] data,
  output logic [HASH_W-1:0]   digest
);

  logic [HASH_W-1:0] digest_r;
  logic [HASH_W-1:0] digest_nxt;
  logic [HASH_W-1:0] data_ext;

  always_comb begin
    data_ext = '0;
    data_ext[ID_WIDTH-1:0] = data;
  end

  always_comb begin
    digest_nxt = digest_r;
    if (ctl.clear) begin
      digest_nxt = '0;
    end else if (ctl.load) begin
      digest_nxt = FNV_BASIS;
    end else if (ctl.step) begin
      digest_nxt = fnv_step(digest_r, data_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digest_r <= '0;
    end else begin
      digest_r <= digest_nxt;
    end
  end

  assign digest = digest_r;

endmodule

// ===== hw/rtl/sis_chk.sv =====
// Port-level checker for the sorted id set, bound to the top level.
// Depends on sis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sis_chk
  import sis_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic [31:0] in_entry_id,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic        out_overflow,
  input logic [5:0]  out_entry_count,
  input logic [63:0] out_set_hash
);

  // Hold a stalled result word.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_set_hash) && $stable(out_entry_count) && $stable(out_found) && $stable(out_overflow))

  // One command in flight: no new word while a result is pending.
  `ASSERT_CLK(a_one_cmd, !(in_ready && out_valid))

  // A clear answers in the next cycle with an empty set and a zero hash.
  `ASSERT_CLK(a_clear, in_valid && in_ready && in_command == CMD_CLEAR |=> out_valid && out_entry_count == 6'd0 && out_set_hash == 64'd0 && !out_found)

  `ASSERT_CLK(a_ovf_absent, out_valid && out_overflow |-> !out_found)

  `ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid)

endmodule

bind sorted_id_set_with_fnv_hash_unit sis_chk u_sis_chk (.*);

// ===== tb/sis_checker.sv =====
// Checker for the sorted id set: watches both channels, predicts each result word
// and compares it field by field. Depends on sis_pkg for command codes, the capacity and the basis.
module sis_checker
  import sis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_entry_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_found,
  input  logic        out_overflow,
  input  logic [5:0]  out_entry_count,
  input  logic [63:0] out_set_hash,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SET_DEPTH = CAPACITY_DEF;
  localparam logic [63:0] HASH_MULT = 64'h0000_0100_0000_01B3;

  typedef struct packed {
    logic        found;
    logic        overflow;
    logic [5:0]  entry_count;
    logic [63:0] set_hash;
  } set_reply_t;

  logic [31:0] shadow_ids [SET_DEPTH];
  int          shadow_count  = 0;
  logic [63:0] shadow_digest = '0;
  set_reply_t  reply_q [$];
  int          err_count     = 0;
  int          pending_count = 0;

  assign mismatches  = err_count;
  assign outstanding = pending_count;

  // Walk the held ids in ascending order: xor in, then multiply modulo 2^64.
  function automatic logic [63:0] digest_of_ids();
    logic [63:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < shadow_count; i++) begin
      h = (h ^ {32'b0, shadow_ids[i]}) * HASH_MULT;
    end
    return h;
  endfunction

  task automatic apply_command(input logic [1:0] cmd, input logic [31:0] id,
                               output set_reply_t r);
    int slot;
    bit present;
    slot = 0;
    while (slot < shadow_count && shadow_ids[slot] < id) slot++;
    present    = (slot < shadow_count) && (shadow_ids[slot] == id);
    r.found    = 1'b0;
    r.overflow = 1'b0;
    case (cmd)
      CMD_ADD: begin
        r.found = present;
        if (!present) begin
          if (shadow_count >= SET_DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            for (int i = shadow_count; i > slot; i--) shadow_ids[i] = shadow_ids[i-1];
            shadow_ids[slot] = id;
            shadow_count++;
            shadow_digest = digest_of_ids();
          end
        end
      end
      CMD_REMOVE: begin
        r.found = present;
        if (present) begin
          for (int i = slot; i + 1 < shadow_count; i++) shadow_ids[i] = shadow_ids[i+1];
          shadow_count--;
          shadow_digest = digest_of_ids();
        end
      end
      CMD_QUERY: begin
        r.found = present;
      end
      CMD_CLEAR: begin
        shadow_count  = 0;
        shadow_digest = '0;
      end
    endcase
    r.entry_count = shadow_count[5:0];
    r.set_hash    = shadow_digest;
  endtask

  always @(posedge clk) begin
    set_reply_t want;
    if (!rst_n) begin
      shadow_count  = 0;
      shadow_digest = '0;
      reply_q.delete();
    end else begin
      // Check the result word first: it belongs to an older command.
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("result word with no command outstanding");
          err_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            err_count++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
            err_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
            err_count++;
          end
          if (out_set_hash !== want.set_hash) begin
            $error("set_hash: expected %h, got %h", want.set_hash, out_set_hash);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_command, in_entry_id, want);
        reply_q.push_back(want);
      end
    end
    pending_count = reply_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the sorted id set testbench: clock, reset, command stimulus and verdict.
// Depends on sis_pkg, the block sorted_id_set_with_fnv_hash_unit and sis_checker.
module tb
  import sis_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1500;
  localparam int IDLE_PCT     = 26;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_entry_id;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic        out_overflow;
  logic [5:0]  out_entry_count;
  logic [63:0] out_set_hash;
  int          mismatches;
  int          outstanding;

  bit          gaps_on      = 1'b1;
  bit          hold_request = 1'b0;
  int          words_sent   = 0;
  logic [31:0] id_pool [$];

  sorted_id_set_with_fnv_hash_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count),
    .out_set_hash    (out_set_hash)
  );

  sis_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count),
    .out_set_hash    (out_set_hash),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one command word and hold it until the block takes it.
  task automatic push_command(input logic [1:0] cmd, input logic [31:0] id);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_entry_id <= id;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  function automatic logic [31:0] pick_pool_id();
    return id_pool[$urandom_range(id_pool.size() - 1)];
  endfunction

  // Build a pool of ids: scattered, clustered around a base, or with the extremes mixed in.
  task automatic fill_pool(input int size);
    logic [31:0] base;
    int          flavor;
    id_pool.delete();
    base   = $urandom;
    flavor = $urandom_range(2);
    for (int i = 0; i < size; i++) begin
      if (flavor == 0) id_pool.push_back($urandom);
      else if (flavor == 1) id_pool.push_back(base + $urandom_range(63));
      else if ($urandom_range(7) == 0) id_pool.push_back($urandom_range(1) ? 32'hFFFF_FFFF : '0);
      else id_pool.push_back($urandom);
    end
  endtask

  // Receiver: random backpressure, and one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stop the run when nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("sorted_id_set_with_fnv_hash_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int          span;
    int          pick;
    int          start_words;
    logic [31:0] fill_base;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_ADD;
    in_entry_id = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-set corners, extremes, duplicates, removal to empty, clear.
    push_command(CMD_QUERY,  32'h0000_0000);
    push_command(CMD_REMOVE, 32'h0000_0005);
    push_command(CMD_ADD,    32'hFFFF_FFFF);
    push_command(CMD_ADD,    32'h0000_0000);
    push_command(CMD_ADD,    32'h0000_0000);
    push_command(CMD_ADD,    32'h8000_0000);
    push_command(CMD_ADD,    32'h7FFF_FFFF);
    push_command(CMD_QUERY,  32'h8000_0000);
    push_command(CMD_QUERY,  32'h0000_0001);
    push_command(CMD_REMOVE, 32'h0000_0000);
    push_command(CMD_REMOVE, 32'h0000_0000);
    push_command(CMD_REMOVE, 32'hFFFF_FFFF);
    push_command(CMD_REMOVE, 32'h8000_0000);
    push_command(CMD_REMOVE, 32'h7FFF_FFFF);
    push_command(CMD_QUERY,  32'h7FFF_FFFF);
    push_command(CMD_CLEAR,  32'hFFFF_FFFF);
    push_command(CMD_QUERY,  32'hFFFF_FFFF);
    push_command(CMD_ADD,    32'hA5A5_5A5A);
    push_command(CMD_CLEAR,  32'h0000_0000);
    push_command(CMD_REMOVE, 32'h0000_0003);
    push_command(CMD_ADD,    32'h5A5A_A5A5);

    // Fill to capacity in shuffled order, then overflow, duplicate when full, drain one.
    start_words = words_sent;
    fill_base   = $urandom;
    for (int i = 0; i < CAPACITY_DEF; i++) begin
      push_command(CMD_ADD, fill_base ^ (i * 32'h9E37_79B9));
    end
    push_command(CMD_ADD,    $urandom);
    push_command(CMD_ADD,    fill_base);
    push_command(CMD_REMOVE, fill_base ^ 32'h9E37_79B9);
    push_command(CMD_ADD,    32'hFFFF_FFFF);
    push_command(CMD_ADD,    32'h0000_0000);
    start_words = words_sent;

    // Random episodes: pool-driven well-formed traffic plus some noise.
    while (words_sent - start_words < RANDOM_WORDS) begin
      fill_pool($urandom_range(4) == 0 ? $urandom_range(1, 6) : $urandom_range(8, 48));
      span = $urandom_range(20, 120);
      for (int k = 0; k < span; k++) begin
        if (words_sent - start_words == 300) hold_request = 1'b1;
        gaps_on = !((words_sent - start_words) inside {[700:1000]});
        pick = $urandom_range(99);
        if (pick < 50) push_command(CMD_ADD, pick_pool_id());
        else if (pick < 70) push_command(CMD_REMOVE, pick_pool_id());
        else if (pick < 85) push_command(CMD_QUERY, pick_pool_id());
        else if (pick < 88) push_command(CMD_CLEAR, $urandom);
        else push_command(2'($urandom_range(3)), $urandom);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("sorted_id_set_with_fnv_hash_unit: match");
    end else begin
      $display("sorted_id_set_with_fnv_hash_unit: mismatch");
    end
    $finish;
  end

endmodule
